@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gdb_pkg.sv @@
// Shared widths, types, and the day-of-year function for the day-difference block.
package gdb_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int DIFF_W  = 23;
    localparam int DOY_W   = 9;
    localparam int ACC_W   = 25;
    localparam int C100_W  = 7;
    localparam int C400_W  = 9;

    localparam logic [DOY_W-1:0]        YEAR_DAYS    = 9'd365;
    localparam logic [C100_W-1:0]       CENTURY_LAST = 7'd99;
    localparam logic [C400_W-1:0]       CYCLE_LAST   = 9'd399;
    localparam logic signed [ACC_W-1:0] DIFF_MAX     = 25'sd4194303;
    localparam logic [DIFF_W-1:0]       DIFF_FLOOR   = DIFF_W'(-366);
    localparam logic [MONTH_W-1:0]      MARCH        = 4'd3;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SWEEP     = 6'b000010,
        ST_END_DOY   = 6'b000100,
        ST_START_LEN = 6'b001000,
        ST_START_DOY = 6'b010000,
        ST_RESULT    = 6'b100000
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } yc_ctrl_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic              leap;
    } yc_stat_t;

    // Length of a year: 365, plus one for a leap year.
    function automatic logic [DOY_W-1:0] year_len(input logic leap);
        return YEAR_DAYS + DOY_W'(leap);
    endfunction

    // Month 0 counts as January, months above 12 as December; day is not checked.
    function automatic logic [DOY_W-1:0] day_of_year(
        input logic [MONTH_W-1:0] month,
        input logic [DAY_W-1:0]   day,
        input logic               leap
    );
        logic [DOY_W-1:0] base;
        unique case (month) inside
            4'd0, 4'd1: base = 9'd0;
            4'd2:       base = 9'd31;
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            default:    base = 9'd334;
        endcase
        return base + DOY_W'(leap && (month >= MARCH)) + DOY_W'(day);
    endfunction

endpackage

@@ hdl/gdb_if.sv @@
// Valid/ready channel interfaces for date pairs and day-difference results.
interface gdb_date_if;
    logic                        valid;
    logic                        ready;
    logic [gdb_pkg::MONTH_W-1:0] start_month;
    logic [gdb_pkg::DAY_W-1:0]   start_mday;
    logic [gdb_pkg::YEAR_W-1:0]  start_year;
    logic [gdb_pkg::MONTH_W-1:0] end_month;
    logic [gdb_pkg::DAY_W-1:0]   end_day;
    logic [gdb_pkg::YEAR_W-1:0]  end_year;

    modport source (
        output valid, start_month, start_mday, start_year, end_month, end_day, end_year,
        input  ready
    );
    modport sink (
        input  valid, start_month, start_mday, start_year, end_month, end_day, end_year,
        output ready
    );
endinterface

interface gdb_span_if;
    logic                              valid;
    logic                              ready;
    logic signed [gdb_pkg::DIFF_W-1:0] day_difference;
    logic                              order_error;

    modport source (
        output valid, day_difference, order_error,
        input  ready
    );
    modport sink (
        input  valid, day_difference, order_error,
        output ready
    );
endinterface

@@ hdl/gregorian_days_between_dates.sv @@
// Top level: days from a start date to an end date under Gregorian leap rules.
// One transaction on dates carries a start and an end date; one transaction on span
// returns the signed day count. The block handles one date pair at a time: dates.ready
// is high only while the sequencer is idle. After a pair is taken, a year counter
// sweeps from year 0 up to the end year, one year per cycle, tracking the leap test
// with running mod-100 and mod-400 counts, and the shared adder adds 365 or 366 for
// every year strictly between the two years. Three more adder steps add the end
// day-of-year and the days left in the start year, then the result state loads the
// output register. When the end year precedes the start year the sweep is
// skipped and the sequencer goes straight to its result state; that result has
// order_error set and day_difference zero, and it loads as soon as the output
// register is free to take it.
// Dates within one year give end day-of-year minus start day-of-year, which may be
// negative. Month 0 counts as January, months above 12 as December, and days are used
// as given without checking. Counts above 4194303 saturate there. The output register
// holds a result until span.ready takes it, and a new pair may be accepted meanwhile;
// the sequencer only stalls at its final step if the previous result is still waiting.
module gregorian_days_between_dates (
    input  logic       clk,
    input  logic       rst_n,
    gdb_date_if.sink   dates,
    gdb_span_if.source span
);

    gdb_pkg::state_t state_reg, state_next;

    // latched date pair
    logic [gdb_pkg::MONTH_W-1:0] sm_reg, em_reg;
    logic [gdb_pkg::DAY_W-1:0]   sd_reg, ed_reg;
    logic [gdb_pkg::YEAR_W-1:0]  sy_reg, ey_reg;

    // leap flags of the two years, captured during the sweep
    logic leap_s_reg, leap_s_next;
    logic leap_e_reg, leap_e_next;
    logic err_reg, err_next;

    logic signed [gdb_pkg::ACC_W-1:0] acc_reg, acc_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic signed [gdb_pkg::DIFF_W-1:0] out_diff_reg, out_diff_next;
    logic                              out_err_reg, out_err_next;

    logic accept;
    logic out_free;
    logic load_out;

    gdb_pkg::yc_ctrl_t yc_ctrl;
    gdb_pkg::yc_stat_t yc_stat;

    logic signed [gdb_pkg::ACC_W-1:0] add_b;
    logic                             add_sub;
    logic signed [gdb_pkg::ACC_W-1:0] add_sum;

    logic in_between;
    logic at_end_year;

    assign dates.ready = (state_reg == gdb_pkg::ST_IDLE);
    assign accept      = dates.valid && dates.ready;
    assign out_free    = !out_valid_reg || span.ready;
    assign load_out    = (state_reg == gdb_pkg::ST_RESULT) && out_free;

    assign in_between  = (yc_stat.year > sy_reg) && (yc_stat.year < ey_reg);
    assign at_end_year = (yc_stat.year == ey_reg);

    assign yc_ctrl.clear = accept;
    assign yc_ctrl.step  = (state_reg == gdb_pkg::ST_SWEEP) && !at_end_year;

    gdb_year_ctr u_year_ctr (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (yc_ctrl),
        .stat  (yc_stat)
    );

    // operand select for the shared adder
    always_comb
    begin
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            gdb_pkg::ST_SWEEP:
            begin
                add_b = gdb_pkg::ACC_W'(gdb_pkg::year_len(yc_stat.leap));
            end
            gdb_pkg::ST_END_DOY:
            begin
                add_b = gdb_pkg::ACC_W'(gdb_pkg::day_of_year(em_reg, ed_reg, leap_e_reg));
            end
            gdb_pkg::ST_START_LEN:
            begin
                // same-year case skips the start year length
                if (sy_reg != ey_reg)
                begin
                    add_b = gdb_pkg::ACC_W'(gdb_pkg::year_len(leap_s_reg));
                end
            end
            gdb_pkg::ST_START_DOY:
            begin
                add_b   = gdb_pkg::ACC_W'(gdb_pkg::day_of_year(sm_reg, sd_reg, leap_s_reg));
                add_sub = 1'b1;
            end
            default:
            begin
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    gdb_addsub u_addsub (
        .a   (acc_reg),
        .b   (add_b),
        .sub (add_sub),
        .sum (add_sum)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        leap_s_next = leap_s_reg;
        leap_e_next = leap_e_reg;
        err_next    = err_reg;
        unique case (state_reg)
            gdb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    acc_next = '0;
                    err_next = (dates.end_year < dates.start_year);
                    state_next = (dates.end_year < dates.start_year) ?
                                 gdb_pkg::ST_RESULT : gdb_pkg::ST_SWEEP;
                end
            end
            gdb_pkg::ST_SWEEP:
            begin
                if (yc_stat.year == sy_reg)
                begin
                    leap_s_next = yc_stat.leap;
                end
                if (at_end_year)
                begin
                    leap_e_next = yc_stat.leap;
                    state_next  = gdb_pkg::ST_END_DOY;
                end
                if (in_between)
                begin
                    acc_next = add_sum;
                end
            end
            gdb_pkg::ST_END_DOY:
            begin
                acc_next   = add_sum;
                state_next = gdb_pkg::ST_START_LEN;
            end
            gdb_pkg::ST_START_LEN:
            begin
                acc_next   = add_sum;
                state_next = gdb_pkg::ST_START_DOY;
            end
            gdb_pkg::ST_START_DOY:
            begin
                acc_next   = add_sum;
                state_next = gdb_pkg::ST_RESULT;
            end
            gdb_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = gdb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdb_pkg::ST_IDLE;
            end
        endcase
    end

    // output register: load on finish, clear once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_diff_next  = out_diff_reg;
        out_err_next   = out_err_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_err_next   = err_reg;
            if (err_reg)
            begin
                out_diff_next = '0;
            end
            else if (acc_reg > gdb_pkg::DIFF_MAX)
            begin
                out_diff_next = gdb_pkg::DIFF_MAX[gdb_pkg::DIFF_W-1:0];
            end
            else
            begin
                out_diff_next = acc_reg[gdb_pkg::DIFF_W-1:0];
            end
        end
        else if (span.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sm_reg <= dates.start_month;
            sd_reg <= dates.start_mday;
            sy_reg <= dates.start_year;
            em_reg <= dates.end_month;
            ed_reg <= dates.end_day;
            ey_reg <= dates.end_year;
        end
        acc_reg      <= acc_next;
        leap_s_reg   <= leap_s_next;
        leap_e_reg   <= leap_e_next;
        err_reg      <= err_next;
        out_diff_reg <= out_diff_next;
        out_err_reg  <= out_err_next;
    end

    assign span.valid          = out_valid_reg;
    assign span.day_difference = out_diff_reg;
    assign span.order_error    = out_err_reg;

endmodule

@@ hdl/gdb_year_ctr.sv @@
// Year sweep counter with running mod-100 and mod-400 counts for the leap test.
module gdb_year_ctr (
    input  logic              clk,
    input  logic              rst_n,
    input  gdb_pkg::yc_ctrl_t ctrl,
    output gdb_pkg::yc_stat_t stat
);

    logic [gdb_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [gdb_pkg::C100_W-1:0] c100_reg, c100_next;
    logic [gdb_pkg::C400_W-1:0] c400_reg, c400_next;

    always_comb
    begin
        year_next = year_reg;
        c100_next = c100_reg;
        c400_next = c400_reg;
        if (ctrl.clear)
        begin
            year_next = '0;
            c100_next = '0;
            c400_next = '0;
        end
        else if (ctrl.step)
        begin
            year_next = year_reg + 1'b1;
            c100_next = (c100_reg == gdb_pkg::CENTURY_LAST) ? '0 : c100_reg + 1'b1;
            c400_next = (c400_reg == gdb_pkg::CYCLE_LAST) ? '0 : c400_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg <= '0;
            c100_reg <= '0;
            c400_reg <= '0;
        end
        else
        begin
            year_reg <= year_next;
            c100_reg <= c100_next;
            c400_reg <= c400_next;
        end
    end

    // leap: divisible by 4 and not by 100, or divisible by 400
    assign stat.year = year_reg;
    assign stat.leap = ((year_reg[1:0] == 2'b00) && (c100_reg != '0)) || (c400_reg == '0);

endmodule

@@ hdl/gdb_addsub.sv @@
// Shared accumulator adder/subtractor used by the sweep and the day-count steps of the sequencer.
module gdb_addsub (
    input  logic signed [gdb_pkg::ACC_W-1:0] a,
    input  logic signed [gdb_pkg::ACC_W-1:0] b,
    input  logic                             sub,
    output logic signed [gdb_pkg::ACC_W-1:0] sum
);

    logic [gdb_pkg::ACC_W-1:0] b_eff;

    assign b_eff = sub ? ~b : b;
    assign sum   = a + b_eff + gdb_pkg::ACC_W'(sub);

endmodule

@@ hdl/gdb_checker.sv @@
// Port-level checker for the day-difference block, with its bind statement.
`include "assert_macros.svh"

module gdb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [gdb_pkg::DIFF_W-1:0]  out_day_difference,
    input logic                        out_order_error
);

    // one pair at a time: busy right after a transaction is taken
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // order error always comes with a zero count
    `ASSERT_IMPLIES(a_err_zero, out_valid && out_order_error, out_day_difference == '0, "err count")

    // negative counts only arise within one year, so never below -366
    `ASSERT_IMPLIES(a_neg_floor, out_valid && out_day_difference[gdb_pkg::DIFF_W-1],
        out_day_difference >= gdb_pkg::DIFF_FLOOR, "negative count out of range")

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_day_difference) && $stable(out_order_error), "result dropped")

endmodule

bind gregorian_days_between_dates gdb_checker u_gdb_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (dates.valid),
    .in_ready           (dates.ready),
    .out_valid          (span.valid),
    .out_ready          (span.ready),
    .out_day_difference (span.day_difference),
    .out_order_error    (span.order_error)
);
